// ===== design/dccdmp_pkg.sv =====
// shared types, codes and constants for the dcc direct mode programmer
package dccdmp_pkg;

  // sample and history geometry
  localparam int SAMPLE_BITS = 10;
  // taps 0 and 10 form the baseline, taps 2 to 5 are checked for the pulse
  localparam int ACK_FAR_TAP = 10;
  localparam int ACK_FIRST_TAP = 2;
  localparam int ACK_LAST_TAP = 5;
  // entries kept before the shift: tap 0 comes straight from the new sample
  localparam int HIST_KEEP = ACK_FAR_TAP;

  // command and data constants of a direct mode packet
  localparam logic [7:0] CMD_WRITE_BYTE = 8'h7C;
  localparam logic [7:0] CMD_VERIFY_BYTE = 8'h74;
  localparam logic [7:0] CMD_BIT_MANIP = 8'h78;
  localparam logic [3:0] BIT_WRITE_HI = 4'hF;
  localparam logic [3:0] BIT_VERIFY_HI = 4'hE;
  localparam logic [15:0] CV_ADDR_MAX = 16'h03FF;
  localparam logic [2:0] LEN_RESET_PKT = 3'd3;
  localparam logic [2:0] LEN_DIRECT_PKT = 3'd4;

  // register reset values
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd500;
  localparam logic [9:0] ACK_MARGIN_RST = 10'd5;
  localparam logic [3:0] RESET_COUNT_RST = 4'd3;
  localparam logic [3:0] DIRECT_COUNT_RST = 4'd5;
  localparam logic [3:0] RECOVERY_COUNT_RST = 4'd6;

  typedef enum logic [2:0] {
    MODE_WRITE_BYTE = 3'd0,
    MODE_VERIFY_BYTE = 3'd1,
    MODE_WRITE_BIT = 3'd2,
    MODE_VERIFY_BIT = 3'd3,
    MODE_TX_DONE = 3'd4,
    MODE_SAMPLE = 3'd5,
    MODE_TICK = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    OUT_ACK = 3'd0,
    OUT_NACK = 3'd1,
    OUT_TIMEOUT = 3'd2,
    OUT_BUSY = 3'd3,
    OUT_BAD_ADDR = 3'd4
  } outcome_t;

  typedef enum logic {
    KIND_PACKET = 1'b0,
    KIND_OUTCOME = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    CFG_TIMEOUT_TICKS = 3'd0,
    CFG_ACK_MARGIN = 3'd1,
    CFG_RESET_COUNT = 3'd2,
    CFG_DIRECT_COUNT = 3'd3,
    CFG_RECOVERY_COUNT = 3'd4
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_INIT = 4'b0010,
    PH_DIRECT = 4'b0100,
    PH_RECOVER = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [9:0] ack_margin;
    logic [3:0] reset_count;
    logic [3:0] direct_count;
    logic [3:0] recovery_count;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    logic [15:0] cv_address;
    logic [7:0] cv_value;
    logic [2:0] bit_position;
    logic [SAMPLE_BITS-1:0] sample;
    logic [7:0] done_tag;
  } item_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } pkt_t;

  typedef struct packed {
    kind_t kind;
    logic [2:0] packet_length;
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
    logic [7:0] packet_tag;
    outcome_t outcome;
  } result_t;

endpackage

// ===== design/dcc_direct_mode_programmer.sv =====
// top level: stream ports, configuration registers, input and result registers
// a request is taken into the input register and moves on when the result
// slot frees, through the single-pass sequencer update into the result register
// throughput: one request per cycle while the result slot is not held
// reset: synchronous, clears phase, counters, tags and sample history, loads
// the register defaults; no clearing pass, requests are taken right after reset
module dcc_direct_mode_programmer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cv_address[15:0], cv_value[23:16], bit_position[26:24], sample[36:27],
  // done_tag[44:37], zero pad
  input  logic [47:0] s_tdata,
  // mode[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // packet_length[2:0], byte_zero[10:3], byte_one[18:11], byte_two[26:19],
  // byte_three[34:27], packet_tag[42:35], outcome[45:43], zero pad
  output logic [47:0] m_tdata,
  // kind[0]
  output logic        m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dccdmp_pkg::*;

  cfg_t cfg;
  item_t item_q;
  logic in_valid;
  logic go;
  logic seq_valid;
  result_t seq_res;
  result_t out_q;
  logic ack_pulse;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg.ack_margin <= ACK_MARGIN_RST;
      cfg.reset_count <= RESET_COUNT_RST;
      cfg.direct_count <= DIRECT_COUNT_RST;
      cfg.recovery_count <= RECOVERY_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        CFG_ACK_MARGIN: cfg.ack_margin <= cfg_data[9:0];
        CFG_RESET_COUNT: cfg.reset_count <= cfg_data[3:0];
        CFG_DIRECT_COUNT: cfg.direct_count <= cfg_data[3:0];
        CFG_RECOVERY_COUNT: cfg.recovery_count <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // request handshake: the held request moves on when the result slot frees
  assign go = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_q.mode <= mode_t'(s_tuser);
      item_q.cv_address <= s_tdata[15:0];
      item_q.cv_value <= s_tdata[23:16];
      item_q.bit_position <= s_tdata[26:24];
      item_q.sample <= s_tdata[36:27];
      item_q.done_tag <= s_tdata[44:37];
    end
  end

  dccdmp_ack_detect u_ack (
    .clk        (clk),
    .rst        (rst),
    .shift      (go && item_q.mode == MODE_SAMPLE),
    .sample     (item_q.sample),
    .ack_margin (cfg.ack_margin),
    .ack_pulse  (ack_pulse)
  );

  dccdmp_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (item_q),
    .cfg       (cfg),
    .ack_pulse (ack_pulse),
    .res_valid (seq_valid),
    .res       (seq_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && seq_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && seq_valid) out_q <= seq_res;
  end

  assign m_tuser = out_q.kind;
  assign m_tdata = {2'b00, out_q.outcome, out_q.packet_tag, out_q.byte_three,
                    out_q.byte_two, out_q.byte_one, out_q.byte_zero, out_q.packet_length};

endmodule

// ===== design/dccdmp_ack_detect.sv =====
// current sample history and acknowledge pulse detector
module dccdmp_ack_detect (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            shift,
  input  logic [dccdmp_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [9:0]                      ack_margin,
  output logic                            ack_pulse
);
  import dccdmp_pkg::*;

  // history before the shift, entry 0 is the newest stored sample
  logic [SAMPLE_BITS-1:0] hist [HIST_KEEP];
  logic [SAMPLE_BITS:0] base_sum;
  logic [SAMPLE_BITS:0] thr;
  logic [ACK_LAST_TAP-ACK_FIRST_TAP:0] over;

  // shift line of samples
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HIST_KEEP; i++) hist[i] <= '0;
    end else if (shift) begin
      hist[0] <= sample;
      for (int i = 1; i < HIST_KEEP; i++) hist[i] <= hist[i-1];
    end
  end

  // threshold from the history after the new sample shifts in
  assign base_sum = {1'b0, sample} + {1'b0, hist[ACK_FAR_TAP-1]};
  assign thr = {1'b0, base_sum[SAMPLE_BITS:1]} + (SAMPLE_BITS+1)'(ack_margin);

  // new tap k is old entry k-1
  always_comb begin
    for (int k = ACK_FIRST_TAP; k <= ACK_LAST_TAP; k++) begin
      over[k-ACK_FIRST_TAP] = {1'b0, hist[k-1]} > thr;
    end
  end

  assign ack_pulse = &over;

endmodule

// ===== design/dccdmp_sequencer.sv =====
// phase sequencer: packet building, packet emission, timeout and outcome
module dccdmp_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  dccdmp_pkg::item_t   item,
  input  dccdmp_pkg::cfg_t    cfg,
  input  logic                ack_pulse,
  output logic                res_valid,
  output dccdmp_pkg::result_t res
);
  import dccdmp_pkg::*;

  phase_t phase, phase_next;
  logic [3:0] phase_rem, phase_rem_next;
  logic ack_seen, ack_seen_next;
  logic [15:0] tcount, tcount_next;
  logic [7:0] last_tag, last_tag_next;
  pkt_t direct_pkt, direct_pkt_next;

  logic is_start;
  pkt_t pkt_built;
  logic [7:0] cmd_byte, data_byte;
  phase_t src_phase, adv_phase;
  logic [3:0] adv_rem;
  logic adv_ack;
  logic [7:0] adv_tag;
  pkt_t adv_pkt;
  result_t adv_res;
  logic [15:0] tcount_inc;

  assign is_start = (item.mode == MODE_WRITE_BYTE) || (item.mode == MODE_VERIFY_BYTE) ||
                    (item.mode == MODE_WRITE_BIT) || (item.mode == MODE_VERIFY_BIT);

  // build the direct packet of a start request
  always_comb begin
    unique case (item.mode)
      MODE_WRITE_BYTE: begin
        cmd_byte = CMD_WRITE_BYTE;
        data_byte = item.cv_value;
      end
      MODE_VERIFY_BYTE: begin
        cmd_byte = CMD_VERIFY_BYTE;
        data_byte = item.cv_value;
      end
      MODE_WRITE_BIT: begin
        cmd_byte = CMD_BIT_MANIP;
        data_byte = {BIT_WRITE_HI, item.cv_value[0], item.bit_position};
      end
      default: begin
        cmd_byte = CMD_BIT_MANIP;
        data_byte = {BIT_VERIFY_HI, item.cv_value[0], item.bit_position};
      end
    endcase
    pkt_built.b0 = cmd_byte | {6'd0, item.cv_address[9:8]};
    pkt_built.b1 = item.cv_address[7:0];
    pkt_built.b2 = data_byte;
    pkt_built.b3 = pkt_built.b0 ^ pkt_built.b1 ^ data_byte;
  end

  // advance: next packet or final outcome, skipping empty phases
  always_comb begin
    src_phase = is_start ? PH_INIT : phase;
    adv_phase = src_phase;
    adv_rem = is_start ? cfg.reset_count : phase_rem;
    adv_ack = is_start ? 1'b0 : ack_seen;
    adv_pkt = is_start ? pkt_built : direct_pkt;
    adv_tag = last_tag;
    adv_res = '0;
    if (adv_phase == PH_INIT && adv_rem == 4'd0) begin
      adv_phase = PH_DIRECT;
      adv_rem = cfg.direct_count;
      adv_ack = 1'b0;
    end
    if (adv_phase == PH_DIRECT && adv_rem == 4'd0) begin
      adv_phase = PH_RECOVER;
      adv_rem = cfg.recovery_count;
    end
    if (adv_phase == PH_RECOVER && adv_rem == 4'd0) begin
      adv_res.kind = KIND_OUTCOME;
      adv_res.outcome = adv_ack ? OUT_ACK : OUT_NACK;
      adv_phase = PH_IDLE;
      adv_ack = 1'b0;
    end else begin
      adv_rem = adv_rem - 4'd1;
      adv_tag = last_tag + 8'd1;
      adv_res.kind = KIND_PACKET;
      adv_res.packet_tag = adv_tag;
      if (adv_phase == PH_DIRECT) begin
        adv_res.packet_length = LEN_DIRECT_PKT;
        adv_res.byte_zero = adv_pkt.b0;
        adv_res.byte_one = adv_pkt.b1;
        adv_res.byte_two = adv_pkt.b2;
        adv_res.byte_three = adv_pkt.b3;
      end else begin
        adv_res.packet_length = LEN_RESET_PKT;
      end
    end
  end

  assign tcount_inc = tcount + 16'd1;

  // per-request state update
  always_comb begin
    phase_next = phase;
    phase_rem_next = phase_rem;
    ack_seen_next = ack_seen;
    tcount_next = tcount;
    last_tag_next = last_tag;
    direct_pkt_next = direct_pkt;
    res_valid = 1'b0;
    res = '0;
    unique case (item.mode)
      MODE_WRITE_BYTE, MODE_VERIFY_BYTE, MODE_WRITE_BIT, MODE_VERIFY_BIT: begin
        res_valid = 1'b1;
        if (phase != PH_IDLE) begin
          res.kind = KIND_OUTCOME;
          res.outcome = OUT_BUSY;
        end else if (item.cv_address > CV_ADDR_MAX) begin
          res.kind = KIND_OUTCOME;
          res.outcome = OUT_BAD_ADDR;
        end else begin
          res = adv_res;
          phase_next = adv_phase;
          phase_rem_next = adv_rem;
          ack_seen_next = adv_ack;
          last_tag_next = adv_tag;
          tcount_next = '0;
          direct_pkt_next = pkt_built;
        end
      end
      MODE_TX_DONE: begin
        if (phase != PH_IDLE && item.done_tag == last_tag) begin
          res_valid = 1'b1;
          res = adv_res;
          phase_next = adv_phase;
          phase_rem_next = adv_rem;
          ack_seen_next = adv_ack;
          last_tag_next = adv_tag;
          if (adv_phase != src_phase) tcount_next = '0;
        end
      end
      MODE_SAMPLE: begin
        if ((phase == PH_DIRECT || phase == PH_RECOVER) && ack_pulse) ack_seen_next = 1'b1;
      end
      MODE_TICK: begin
        if (phase != PH_IDLE) begin
          tcount_next = tcount_inc;
          if (tcount_inc >= cfg.timeout_ticks || tcount_inc == 16'd0) begin
            res_valid = 1'b1;
            res.kind = KIND_OUTCOME;
            res.outcome = OUT_TIMEOUT;
            phase_next = PH_IDLE;
            phase_rem_next = '0;
            ack_seen_next = 1'b0;
            tcount_next = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      phase_rem <= '0;
      ack_seen <= 1'b0;
      tcount <= '0;
      last_tag <= '0;
    end else if (go) begin
      phase <= phase_next;
      phase_rem <= phase_rem_next;
      ack_seen <= ack_seen_next;
      tcount <= tcount_next;
      last_tag <= last_tag_next;
    end
  end

  // direct packet store, written by every start that is not rejected
  always_ff @(posedge clk) begin
    if (go) direct_pkt <= direct_pkt_next;
  end

  // an idle sequencer holds no leftover count or acknowledge
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> (phase_rem == 4'd0 && !ack_seen))
    else $error("idle phase with leftover count or ack");

  // every emitted packet advances the tag by one
  a_tag_step: assert property (@(posedge clk) disable iff (rst)
    (go && res_valid && res.kind == KIND_PACKET) |=> last_tag == 8'($past(last_tag) + 8'd1))
    else $error("packet tag did not advance by one");

  // a start rejected as busy leaves the sequence alone
  a_busy_hold: assert property (@(posedge clk) disable iff (rst)
    (go && res_valid && res.kind == KIND_OUTCOME && res.outcome == OUT_BUSY)
    |=> (phase == $past(phase) && phase_rem == $past(phase_rem)))
    else $error("busy rejection changed the sequence");

endmodule
